>>> sv/olid_pkg.sv
`default_nettype none

package olid_pkg;

   localparam int CAPACITY    = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int OP_WIDTH    = 2;
   localparam int POS_WIDTH   = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int STAT_WIDTH  = 2;
   localparam int FILL_WIDTH  = 7;
   localparam int CMP_WIDTH   = POS_WIDTH + 1;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_DELETE = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [STAT_WIDTH-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_POSITION = 2'd1,
      STATUS_FULL         = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> sv/olid_if.sv
`default_nettype none

interface olid_req_if;
   logic                                valid;
   logic                                ready;
   olid_pkg::op_type                    op;
   logic [olid_pkg::POS_WIDTH-1:0]      position;
   logic [olid_pkg::VALUE_WIDTH-1:0]    value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface olid_rsp_if;
   logic                                valid;
   logic                                ready;
   olid_pkg::status_type                status;
   logic                                has_data;
   logic [olid_pkg::VALUE_WIDTH-1:0]    entry_value;
   logic [olid_pkg::FILL_WIDTH-1:0]     fill_after;
   logic                                last;

   modport source (output valid, output status, output has_data, output entry_value,
                   output fill_after, output last, input ready);
   modport sink   (input valid, input status, input has_data, input entry_value,
                   input fill_after, input last, output ready);
endinterface

`default_nettype wire

>>> sv/olid_ram.sv
`default_nettype none

module olid_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/ordered_list_insert_delete.sv
// Ordered list of up to CAPACITY words held in a single-port-write, single-port-read memory.
// One item is taken at a time and req ready is high only while the block is idle. Append
// gives its result in the cycle after it is accepted. Insert and delete move the later
// entries one at a time through the memory's registered read port, each moved entry being
// read in S_MOVE_RD and written in S_MOVE_WR; once no entry is left to move, S_FINISH
// writes the new value of an insert and raises the result. A dump reads each entry in
// S_DUMP_RD, takes its data in S_DUMP_DATA and holds the result in S_RESP, going on to the
// next entry only when rsp ready takes the result. Bad positions and a full list give their
// status in the cycle after acceptance and leave the list unchanged; an empty dump gives a
// single result without data. After its final result is taken the block goes back to idle
// before it takes the next item.

`default_nettype none

module ordered_list_insert_delete (
   input  wire logic   clock,
   input  wire logic   reset,
   olid_req_if.sink    req_chan,
   olid_rsp_if.source  rsp_chan
);

   localparam int AW = olid_pkg::ADDR_WIDTH;
   localparam int CW = olid_pkg::COUNT_WIDTH;
   localparam int DW = olid_pkg::DATA_WIDTH;
   localparam int VW = olid_pkg::VALUE_WIDTH;
   localparam int PW = olid_pkg::POS_WIDTH;
   localparam int XW = olid_pkg::CMP_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_FINISH,
      S_DUMP_RD,
      S_DUMP_DATA,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   olid_pkg::op_type     op_ff, op_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [DW-1:0]        value_ff, value_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        limit_ff, limit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   olid_pkg::status_type status_ff, status_in;
   logic                 has_data_ff, has_data_in;
   logic [VW-1:0]        entry_ff, entry_in;
   logic                 last_ff, last_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DW-1:0]        wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [DW-1:0]        rd_data;

   logic [XW-1:0]        req_pos_x;
   logic [XW-1:0]        fill_x;
   logic [XW-1:0]        idx_x;
   logic [AW-1:0]        step_idx;
   logic                 move_more;
   logic                 full;

   olid_ram #(
      .DEPTH (olid_pkg::CAPACITY),
      .WIDTH (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_pos_x = XW'(req_chan.position);
   assign fill_x    = XW'(fill_ff);
   assign idx_x     = XW'(idx_ff);
   assign full      = fill_x >= XW'(olid_pkg::CAPACITY);

   // The shared step unit: one incrementer or decrementer on the entry index and one compare
   // that decides whether another entry has to move.
   always_comb begin
      if (op_ff == olid_pkg::OP_INSERT) begin
         step_idx  = idx_ff - AW'(1);
         move_more = idx_x >= XW'(pos_ff);
      end else begin
         step_idx  = idx_ff + AW'(1);
         move_more = (idx_x + XW'(1)) < fill_x;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      has_data_in  = has_data_ff;
      entry_in     = entry_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = step_idx;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.op;
               pos_in      = req_chan.position;
               value_in    = DW'(req_chan.value);
               has_data_in = 1'b0;
               entry_in    = '0;
               last_in     = 1'b1;
               status_in   = olid_pkg::STATUS_OK;
               case (req_chan.op)
                  olid_pkg::OP_INSERT: begin
                     if (req_pos_x == '0 || req_pos_x > fill_x + XW'(1)) begin
                        status_in    = olid_pkg::STATUS_BAD_POSITION;
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else if (full) begin
                        status_in    = olid_pkg::STATUS_FULL;
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        idx_in   = AW'(fill_ff);
                        state_in = S_MOVE_RD;
                     end
                  end
                  olid_pkg::OP_APPEND: begin
                     if (full) begin
                        status_in = olid_pkg::STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(fill_ff);
                        wr_data = DW'(req_chan.value);
                        fill_in = fill_ff + CW'(1);
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_RESP;
                  end
                  olid_pkg::OP_DELETE: begin
                     if (req_pos_x == '0 || req_pos_x > fill_x) begin
                        status_in    = olid_pkg::STATUS_BAD_POSITION;
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        idx_in   = AW'(req_chan.position - PW'(1));
                        state_in = S_MOVE_RD;
                     end
                  end
                  default: begin
                     if (fill_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        state_in     = S_RESP;
                     end else begin
                        if (req_pos_x == '0 || req_pos_x > fill_x) begin
                           limit_in = fill_ff;
                        end else begin
                           limit_in = CW'(req_chan.position);
                        end
                        idx_in   = '0;
                        state_in = S_DUMP_RD;
                     end
                  end
               endcase
            end
         end
         S_MOVE_RD: begin
            if (move_more) begin
               rd_en    = 1'b1;
               state_in = S_MOVE_WR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MOVE_WR: begin
            wr_en    = 1'b1;
            idx_in   = step_idx;
            state_in = S_MOVE_RD;
         end
         S_FINISH: begin
            if (op_ff == olid_pkg::OP_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = AW'(pos_ff - PW'(1));
               wr_data = value_ff;
               fill_in = fill_ff + CW'(1);
            end else begin
               fill_in = fill_ff - CW'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_DUMP_DATA;
         end
         S_DUMP_DATA: begin
            rsp_valid_in = 1'b1;
            has_data_in  = 1'b1;
            entry_in     = VW'(rd_data);
            last_in      = (XW'(idx_ff) + XW'(1)) == XW'(limit_ff);
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = step_idx;
                  state_in = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      idx_ff      <= idx_in;
      limit_ff    <= limit_in;
      status_ff   <= status_in;
      has_data_ff <= has_data_in;
      entry_ff    <= entry_in;
      last_ff     <= last_in;
   end

   assign req_chan.ready       = state_ff == S_IDLE;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.has_data    = has_data_ff;
   assign rsp_chan.entry_value = entry_ff;
   assign rsp_chan.fill_after  = olid_pkg::FILL_WIDTH'(fill_ff);
   assign rsp_chan.last        = last_ff;

endmodule

`default_nettype wire

>>> test/ordered_list_insert_delete_tb.sv
`timescale 1ns / 1ps

module ordered_list_insert_delete_tb;

   localparam int TOTAL_OPS  = 360;
   localparam int QUIET_TAIL = 40;
   localparam int LONG_HOLD  = 400;

   typedef struct {
      olid_pkg::op_type                       op;
      logic [olid_pkg::POS_WIDTH-1:0]         position;
      logic [olid_pkg::VALUE_WIDTH-1:0]       value;
   } list_cmd_type;

   typedef struct {
      olid_pkg::status_type                   status;
      logic                                   has_data;
      logic [olid_pkg::VALUE_WIDTH-1:0]       entry_value;
      logic [olid_pkg::FILL_WIDTH-1:0]        fill_after;
      logic                                   last;
   } list_rsp_type;

   typedef enum {PLAN_GROW, PLAN_SHRINK, PLAN_MIX} fill_plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   olid_req_if req_bus();
   olid_rsp_if rsp_bus();

   logic                             drv_valid    = 1'b0;
   olid_pkg::op_type                 drv_op       = olid_pkg::OP_INSERT;
   logic [olid_pkg::POS_WIDTH-1:0]   drv_position = '0;
   logic [olid_pkg::VALUE_WIDTH-1:0] drv_value    = '0;
   logic                             mon_ready    = 1'b0;
   logic                             long_hold    = 1'b0;

   assign req_bus.valid    = drv_valid;
   assign req_bus.op       = drv_op;
   assign req_bus.position = drv_position;
   assign req_bus.value    = drv_value;
   assign rsp_bus.ready    = mon_ready;

   ordered_list_insert_delete u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   list_cmd_type queued_ops[$];
   list_rsp_type awaited_rsps[$];
   list_cmd_type offered_cmd;
   list_rsp_type want;
   int           total_ops    = 0;
   int           ops_accepted = 0;
   int           error_count  = 0;
   int           plan_fill    = 0;
   int           send_gap     = 0;
   int           send_calm    = 0;
   int           stall_left   = 0;
   int           recv_calm    = 0;

   logic [olid_pkg::DATA_WIDTH-1:0] list_words [olid_pkg::CAPACITY];
   int                              list_fill = 0;

   task automatic push_rsp(input olid_pkg::status_type status, input logic has_data,
                           input logic [olid_pkg::VALUE_WIDTH-1:0] word, input logic last);
      list_rsp_type rsp;
      rsp.status      = status;
      rsp.has_data    = has_data;
      rsp.entry_value = word;
      rsp.fill_after  = list_fill[olid_pkg::FILL_WIDTH-1:0];
      rsp.last        = last;
      awaited_rsps.push_back(rsp);
   endtask

   task automatic apply_list_op(input list_cmd_type cmd);
      int pos;
      int count;
      pos = int'(cmd.position);
      case (cmd.op)
         olid_pkg::OP_INSERT: begin
            if (pos < 1 || pos > list_fill + 1) begin
               push_rsp(olid_pkg::STATUS_BAD_POSITION, 1'b0, '0, 1'b1);
            end else if (list_fill >= olid_pkg::CAPACITY) begin
               push_rsp(olid_pkg::STATUS_FULL, 1'b0, '0, 1'b1);
            end else begin
               for (int j = list_fill; j > pos - 1; j--) list_words[j] = list_words[j-1];
               list_words[pos-1] = cmd.value[olid_pkg::DATA_WIDTH-1:0];
               list_fill++;
               push_rsp(olid_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         olid_pkg::OP_APPEND: begin
            if (list_fill >= olid_pkg::CAPACITY) begin
               push_rsp(olid_pkg::STATUS_FULL, 1'b0, '0, 1'b1);
            end else begin
               list_words[list_fill] = cmd.value[olid_pkg::DATA_WIDTH-1:0];
               list_fill++;
               push_rsp(olid_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         olid_pkg::OP_DELETE: begin
            if (pos < 1 || pos > list_fill) begin
               push_rsp(olid_pkg::STATUS_BAD_POSITION, 1'b0, '0, 1'b1);
            end else begin
               for (int j = pos - 1; j + 1 < list_fill; j++) list_words[j] = list_words[j+1];
               list_fill--;
               push_rsp(olid_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end
         end
         default: begin
            if (list_fill == 0) begin
               push_rsp(olid_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end else begin
               count = (pos == 0 || pos > list_fill) ? list_fill : pos;
               for (int j = 0; j < count; j++)
                  push_rsp(olid_pkg::STATUS_OK, 1'b1, list_words[j], j + 1 == count);
            end
         end
      endcase
   endtask

   // Only the fill count is followed here, so that the random part can steer the list
   // towards full and empty.
   task automatic queue_op(input olid_pkg::op_type op, input int pos,
                           input logic [olid_pkg::VALUE_WIDTH-1:0] val);
      list_cmd_type cmd;
      cmd.op       = op;
      cmd.position = pos[olid_pkg::POS_WIDTH-1:0];
      cmd.value    = val;
      queued_ops.push_back(cmd);
      case (op)
         olid_pkg::OP_INSERT:
            if (pos >= 1 && pos <= plan_fill + 1 && plan_fill < olid_pkg::CAPACITY) plan_fill++;
         olid_pkg::OP_APPEND: if (plan_fill < olid_pkg::CAPACITY) plan_fill++;
         olid_pkg::OP_DELETE: if (pos >= 1 && pos <= plan_fill) plan_fill--;
         default: ;
      endcase
   endtask

   function automatic int dump_count();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 0;
      if (pick < 6) return $urandom_range(1, 4);
      if (pick < 8) return plan_fill;
      return $urandom_range(0, 255);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            apply_list_op(offered_cmd);
            ops_accepted++;
         end
         if (!drv_valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               drv_valid <= 1'b0;
            end else if (queued_ops.size() > QUIET_TAIL && send_calm == 0 &&
                         $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 19) - 1;
               drv_valid <= 1'b0;
               if ($urandom_range(0, 3) == 0) send_calm = $urandom_range(20, 80);
            end else if (queued_ops.size() != 0) begin
               offered_cmd = queued_ops.pop_front();
               drv_valid    <= 1'b1;
               drv_op       <= offered_cmd.op;
               drv_position <= offered_cmd.position;
               drv_value    <= offered_cmd.value;
               if (send_calm > 0) send_calm--;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         mon_ready <= 1'b0;
         stall_left = 0;
         recv_calm = 0;
      end else begin
         if (rsp_bus.valid && mon_ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("item received with no result awaited");
               error_count++;
            end else begin
               want = awaited_rsps.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                  error_count++;
               end
               if (rsp_bus.has_data !== want.has_data) begin
                  $error("has_data: expected %0d, actual %0d", want.has_data, rsp_bus.has_data);
                  error_count++;
               end
               if (rsp_bus.entry_value !== want.entry_value) begin
                  $error("entry_value: expected %h, actual %h", want.entry_value,
                         rsp_bus.entry_value);
                  error_count++;
               end
               if (rsp_bus.fill_after !== want.fill_after) begin
                  $error("fill_after: expected %0d, actual %0d", want.fill_after,
                         rsp_bus.fill_after);
                  error_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
                  error_count++;
               end
            end
         end
         if (long_hold) begin
            mon_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            mon_ready <= 1'b0;
         end else if (queued_ops.size() > QUIET_TAIL && recv_calm == 0 &&
                      $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            mon_ready <= 1'b0;
            if ($urandom_range(0, 3) == 0) recv_calm = $urandom_range(20, 80);
         end else begin
            mon_ready <= 1'b1;
            if (recv_calm > 0) recv_calm--;
         end
      end
   end

   // The receiver holds off for a long stretch so that the block backs up into its input.
   initial begin
      wait (ops_accepted >= 200);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #25_000_000;
      $display("ordered_list_insert_delete: mismatch");
      $finish;
   end

   initial begin
      fill_plan_type plan;
      int            low_mark;
      int            full_probes;
      int            mix_left;
      plan        = PLAN_GROW;
      low_mark    = 0;
      full_probes = 0;
      mix_left    = 0;

      queue_op(olid_pkg::OP_DUMP,   0,   '0);
      queue_op(olid_pkg::OP_DELETE, 1,   32'h0000_0001);
      queue_op(olid_pkg::OP_DELETE, 0,   '0);
      queue_op(olid_pkg::OP_INSERT, 0,   32'hFFFF_FFFF);
      queue_op(olid_pkg::OP_INSERT, 2,   32'h1111_1111);
      queue_op(olid_pkg::OP_INSERT, 1,   32'hFFFF_FFFF);
      queue_op(olid_pkg::OP_APPEND, 0,   32'h0000_0000);
      queue_op(olid_pkg::OP_INSERT, 1,   32'h8000_0001);
      queue_op(olid_pkg::OP_INSERT, 4,   32'h5A5A_5A5A);
      queue_op(olid_pkg::OP_INSERT, 6,   32'hA5A5_A5A5);
      queue_op(olid_pkg::OP_INSERT, 255, 32'h7FFF_FFFE);
      queue_op(olid_pkg::OP_DUMP,   0,   '0);
      queue_op(olid_pkg::OP_DUMP,   2,   '0);
      queue_op(olid_pkg::OP_DUMP,   255, '0);
      queue_op(olid_pkg::OP_DELETE, 5,   '0);
      queue_op(olid_pkg::OP_DELETE, 2,   '0);
      queue_op(olid_pkg::OP_DELETE, 3,   '0);
      queue_op(olid_pkg::OP_DELETE, 128, '0);
      queue_op(olid_pkg::OP_DUMP,   1,   '0);
      queue_op(olid_pkg::OP_DELETE, 1,   '0);
      queue_op(olid_pkg::OP_DELETE, 1,   '0);
      queue_op(olid_pkg::OP_DUMP,   3,   '0);
      queue_op(olid_pkg::OP_APPEND, 0,   32'h1234_5678);
      queue_op(olid_pkg::OP_DUMP,   0,   '0);

      while (queued_ops.size() < TOTAL_OPS) begin
         if ($urandom_range(0, 11) == 0) begin
            queue_op(olid_pkg::OP_DUMP, dump_count(), $urandom);
         end else if ($urandom_range(0, 19) == 0) begin
            queue_op(olid_pkg::op_type'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom);
         end else begin
            case (plan)
               PLAN_GROW: begin
                  if (plan_fill == olid_pkg::CAPACITY) begin
                     case (full_probes)
                        0: queue_op(olid_pkg::OP_APPEND, $urandom_range(0, 255), $urandom);
                        1: queue_op(olid_pkg::OP_INSERT, plan_fill + 1, $urandom);
                        2: queue_op(olid_pkg::OP_INSERT, $urandom_range(1, plan_fill),
                                    $urandom);
                        default: queue_op(olid_pkg::OP_INSERT, plan_fill + 2, $urandom);
                     endcase
                     full_probes++;
                     if (full_probes >= 4) begin
                        plan = PLAN_SHRINK;
                        low_mark = $urandom_range(0, 6);
                        full_probes = 0;
                     end
                  end else if ($urandom_range(0, 1) == 0) begin
                     queue_op(olid_pkg::OP_APPEND, $urandom_range(0, 255), $urandom);
                  end else begin
                     queue_op(olid_pkg::OP_INSERT, $urandom_range(1, plan_fill + 1), $urandom);
                  end
               end
               PLAN_SHRINK: begin
                  if (plan_fill <= low_mark) begin
                     queue_op(olid_pkg::OP_DELETE,
                              ($urandom_range(0, 1) == 0) ? 0 : plan_fill + 1, $urandom);
                     plan = PLAN_MIX;
                     mix_left = $urandom_range(15, 40);
                  end else begin
                     queue_op(olid_pkg::OP_DELETE, $urandom_range(1, plan_fill), $urandom);
                  end
               end
               default: begin
                  queue_op(olid_pkg::op_type'($urandom_range(0, 2)),
                           $urandom_range(0, plan_fill + 2), $urandom);
                  mix_left--;
                  if (mix_left <= 0) plan = PLAN_GROW;
               end
            endcase
         end
      end
      total_ops = queued_ops.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (ops_accepted == total_ops);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("ordered_list_insert_delete: match");
      end else begin
         $display("ordered_list_insert_delete: mismatch");
      end
      $finish;
   end

endmodule
